// File: src/sra_pkg.sv
`timescale 1ns / 1ps

package sra_pkg;

   // Store depth in bytes; a position p lives in slot p mod CAPACITY
   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 64;
   localparam int PEND_W   = 11;

   // Operation codes
   localparam logic [1:0] OP_SEGMENT = 2'd0;
   localparam logic [1:0] OP_MARKER  = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [POS_W-1:0] stream_index;
      logic [7:0]       data_byte;
      logic             is_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0]        read_byte;
      logic              read_valid;
      logic [POS_W-1:0]  assembled_count;
      logic [PEND_W-1:0] pending_count;
      logic              stream_closed;
   } rsp_item_type;

   // Access to the byte and mark stores, one address each per cycle
   typedef struct packed {
      logic              byte_we;
      logic              byte_re;
      logic [SLOT_W-1:0] byte_addr;
      logic [7:0]        byte_wdata;
      logic              mark_we;
      logic              mark_re;
      logic [SLOT_W-1:0] mark_addr;
      logic              mark_wdata;
   } store_req_type;

endpackage

// File: src/stream_byte_reassembler.sv
`timescale 1ns / 1ps

// Out-of-order byte stream reassembler over a circular store of CAPACITY bytes (1024). One
// item is a segment byte, an end marker or a read; each item gives exactly one result on
// rsp_item, shown for one cycle with rsp_strobe, and the receiver cannot stall it. busy is
// high while an item is in work; start is taken when busy is low. A sequencer drives one
// shared 64-bit adder and single-port byte and mark stores, so an item is worked through in
// steps, and an accepted byte also walks the assembled frontier over each pending byte; a
// new item is taken only after the result, at the earliest in the cycle that shows it.
// After reset the marks are cleared one slot per cycle, and busy stays high until every
// slot is clear.
module stream_byte_reassembler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sra_pkg::req_item_type req_item,
   output logic                 rsp_strobe,
   output sra_pkg::rsp_item_type rsp_item
);

   typedef enum logic [13:0] {
      S_CLEAR    = 14'b00000000000001,
      S_IDLE     = 14'b00000000000010,
      S_SEG_USED = 14'b00000000000100,
      S_SEG_WIN  = 14'b00000000001000,
      S_SEG_WR   = 14'b00000000010000,
      S_SEG_END  = 14'b00000000100000,
      S_SEG_MARK = 14'b00000001000000,
      S_WALK_RD  = 14'b00000010000000,
      S_WALK_EV  = 14'b00000100000000,
      S_CLOSE    = 14'b00001000000000,
      S_MARKER   = 14'b00010000000000,
      S_RD_CHK   = 14'b00100000000000,
      S_RD_INC   = 14'b01000000000000,
      S_RESP     = 14'b10000000000000
   } state_type;

   localparam int SW = sra_pkg::SLOT_W;
   localparam int CW = sra_pkg::CNT_W;
   localparam int PW = sra_pkg::POS_W;

   state_type             state_ff, state_in;
   sra_pkg::req_item_type item_ff, item_in;
   logic [PW-1:0]         asm_ff, asm_in;
   logic [PW-1:0]         rd_ff, rd_in;
   logic [PW-1:0]         end_ff, end_in;
   logic                  end_known_ff, end_known_in;
   logic                  closed_ff, closed_in;
   logic [CW-1:0]         pend_ff, pend_in;
   logic [SW-1:0]         asm_slot_ff, asm_slot_in;
   logic [SW-1:0]         rd_slot_ff, rd_slot_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [SW-1:0]         clr_ff, clr_in;
   logic [SW-1:0]         offset_ff, offset_in;
   logic [CW-1:0]         used_ff, used_in;
   logic                  full_ff, full_in;
   logic                  rvalid_ff, rvalid_in;
   sra_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic [PW-1:0]          alu_a, alu_b, alu_sum;
   logic                   alu_sub, alu_carry, alu_zero;
   sra_pkg::store_req_type store_req;
   logic [7:0]             byte_rdata;
   logic                   mark_rdata;

   logic                   diff_hi;
   logic                   diff_full;
   logic                   accept;
   logic [SW:0]            pos_sum;
   logic [SW-1:0]          pos_slot;
   logic [SW-1:0]          asm_slot_next;
   logic [SW-1:0]          rd_slot_next;

   sra_alu u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry),
      .zero  (alu_zero)
   );

   sra_store u_store (
      .clock      (clock),
      .req        (store_req),
      .byte_rdata (byte_rdata),
      .mark_rdata (mark_rdata)
   );

   // Difference against the store size, and the window test for a segment byte
   assign diff_hi   = (alu_sum[PW-1:CW] != '0);
   assign diff_full = diff_hi || (alu_sum[CW-1:0] >= CW'(sra_pkg::CAPACITY));
   assign accept    = !closed_ff && !full_ff && alu_carry && !diff_hi &&
                      (({1'b0, alu_sum[CW-1:0]} + {1'b0, used_ff})
                       < (CW+1)'(sra_pkg::CAPACITY));

   // Slot of the segment byte: frontier slot plus offset, wrapped once
   assign pos_sum  = {1'b0, asm_slot_ff} + {1'b0, offset_ff};
   assign pos_slot = (pos_sum >= (SW+1)'(sra_pkg::CAPACITY)) ?
                     SW'(pos_sum - (SW+1)'(sra_pkg::CAPACITY)) : SW'(pos_sum);

   assign asm_slot_next = (asm_slot_ff == SW'(sra_pkg::CAPACITY - 1)) ? '0 : asm_slot_ff + 1'b1;
   assign rd_slot_next  = (rd_slot_ff == SW'(sra_pkg::CAPACITY - 1)) ? '0 : rd_slot_ff + 1'b1;

   // Shared adder operands for each step
   always_comb begin
      alu_a   = asm_ff;
      alu_b   = rd_ff;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_SEG_WIN: begin
            alu_a = item_ff.stream_index;
            alu_b = asm_ff;
         end
         S_SEG_END: begin
            alu_a   = item_ff.stream_index;
            alu_b   = PW'(1);
            alu_sub = 1'b0;
         end
         S_WALK_EV: begin
            alu_b   = PW'(1);
            alu_sub = 1'b0;
         end
         S_CLOSE: begin
            alu_a = end_ff;
            alu_b = asm_ff;
         end
         S_RD_INC: begin
            alu_a   = rd_ff;
            alu_b   = PW'(1);
            alu_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Sequencer: store access and state updates
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      asm_in        = asm_ff;
      rd_in         = rd_ff;
      end_in        = end_ff;
      end_known_in  = end_known_ff;
      closed_in     = closed_ff;
      pend_in       = pend_ff;
      asm_slot_in   = asm_slot_ff;
      rd_slot_in    = rd_slot_ff;
      slot_in       = slot_ff;
      clr_in        = clr_ff;
      offset_in     = offset_ff;
      used_in       = used_ff;
      full_in       = full_ff;
      rvalid_in     = rvalid_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      store_req     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            store_req.mark_we   = 1'b1;
            store_req.mark_addr = clr_ff;
            clr_in              = clr_ff + 1'b1;
            if (clr_ff == SW'(sra_pkg::CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               item_in   = req_item;
               rvalid_in = 1'b0;
               unique case (req_item.operation)
                  sra_pkg::OP_SEGMENT: state_in = S_SEG_USED;
                  sra_pkg::OP_MARKER:  state_in = S_MARKER;
                  sra_pkg::OP_READ:    state_in = S_RD_CHK;
                  default:             state_in = S_RESP;
               endcase
            end
         end

         // Bytes held: assembled minus read
         S_SEG_USED: begin
            used_in  = alu_sum[CW-1:0];
            full_in  = diff_full;
            state_in = S_SEG_WIN;
         end

         // Offset from the frontier; drop outside the window
         S_SEG_WIN: begin
            offset_in = alu_sum[SW-1:0];
            state_in  = accept ? S_SEG_WR : S_RESP;
         end

         // Write the byte, fetch its mark
         S_SEG_WR: begin
            store_req.byte_we    = 1'b1;
            store_req.byte_addr  = pos_slot;
            store_req.byte_wdata = item_ff.data_byte;
            store_req.mark_re    = 1'b1;
            store_req.mark_addr  = pos_slot;
            slot_in              = pos_slot;
            state_in = (item_ff.is_last && !end_known_ff) ? S_SEG_END : S_SEG_MARK;
         end

         S_SEG_END: begin
            end_in       = alu_sum;
            end_known_in = 1'b1;
            state_in     = S_SEG_MARK;
         end

         // Set the mark if new
         S_SEG_MARK: begin
            if (!mark_rdata) begin
               store_req.mark_we    = 1'b1;
               store_req.mark_addr  = slot_ff;
               store_req.mark_wdata = 1'b1;
               pend_in              = pend_ff + 1'b1;
            end
            state_in = S_WALK_RD;
         end

         // Fetch the mark at the frontier and check for a full store
         S_WALK_RD: begin
            store_req.mark_re   = 1'b1;
            store_req.mark_addr = asm_slot_ff;
            full_in             = diff_full;
            state_in            = S_WALK_EV;
         end

         // Advance the frontier over a pending byte
         S_WALK_EV: begin
            if (mark_rdata && !full_ff) begin
               store_req.mark_we   = 1'b1;
               store_req.mark_addr = asm_slot_ff;
               pend_in             = pend_ff - 1'b1;
               asm_in              = alu_sum;
               asm_slot_in         = asm_slot_next;
               state_in            = S_WALK_RD;
            end else begin
               state_in = S_CLOSE;
            end
         end

         S_CLOSE: begin
            if (end_known_ff && alu_zero) begin
               closed_in = 1'b1;
            end
            state_in = S_RESP;
         end

         S_MARKER: begin
            if (item_ff.is_last && !end_known_ff) begin
               end_in       = item_ff.stream_index;
               end_known_in = 1'b1;
            end
            state_in = S_CLOSE;
         end

         // Pop one assembled byte if there is one
         S_RD_CHK: begin
            if (!alu_zero) begin
               store_req.byte_re   = 1'b1;
               store_req.byte_addr = rd_slot_ff;
               rd_slot_in          = rd_slot_next;
               rvalid_in           = 1'b1;
               state_in            = S_RD_INC;
            end else begin
               state_in = S_RESP;
            end
         end

         S_RD_INC: begin
            rd_in    = alu_sum;
            state_in = S_RESP;
         end

         S_RESP: begin
            rsp_in.read_byte       = rvalid_ff ? byte_rdata : 8'd0;
            rsp_in.read_valid      = rvalid_ff;
            rsp_in.assembled_count = asm_ff;
            rsp_in.pending_count   = sra_pkg::PEND_W'(pend_ff);
            rsp_in.stream_closed   = closed_ff;
            rsp_strobe_in          = 1'b1;
            state_in               = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         asm_ff        <= '0;
         rd_ff         <= '0;
         end_ff        <= '0;
         end_known_ff  <= 1'b0;
         closed_ff     <= 1'b0;
         pend_ff       <= '0;
         asm_slot_ff   <= '0;
         rd_slot_ff    <= '0;
         clr_ff        <= '0;
         full_ff       <= 1'b0;
         rvalid_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         asm_ff        <= asm_in;
         rd_ff         <= rd_in;
         end_ff        <= end_in;
         end_known_ff  <= end_known_in;
         closed_ff     <= closed_in;
         pend_ff       <= pend_in;
         asm_slot_ff   <= asm_slot_in;
         rd_slot_ff    <= rd_slot_in;
         clr_ff        <= clr_in;
         full_ff       <= full_in;
         rvalid_ff     <= rvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      slot_ff   <= slot_in;
      offset_ff <= offset_in;
      used_ff   <= used_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_RESP))
      else $error("result strobe without a response step");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= CW'(sra_pkg::CAPACITY))
      else $error("pending count beyond store size");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      (asm_ff - rd_ff) <= PW'(sra_pkg::CAPACITY))
      else $error("assembled bytes overrun the reader");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed stream reopened");

endmodule

// File: src/sra_alu.sv
`timescale 1ns / 1ps

module sra_alu (
   input  logic [sra_pkg::POS_W-1:0] a,
   input  logic [sra_pkg::POS_W-1:0] b,
   input  logic                      sub,
   output logic [sra_pkg::POS_W-1:0] sum,
   output logic                      carry,
   output logic                      zero
);

   logic [sra_pkg::POS_W-1:0] b_op;
   logic [sra_pkg::POS_W:0]   full_sum;

   // Add, or subtract as a plus inverted b plus one; carry set means no borrow
   assign b_op     = sub ? ~b : b;
   assign full_sum = {1'b0, a} + {1'b0, b_op} + {{sra_pkg::POS_W{1'b0}}, sub};
   assign sum      = full_sum[sra_pkg::POS_W-1:0];
   assign carry    = full_sum[sra_pkg::POS_W];
   assign zero     = (full_sum[sra_pkg::POS_W-1:0] == '0);

endmodule

// File: src/sra_store.sv
`timescale 1ns / 1ps

module sra_store (
   input  logic                  clock,
   input  sra_pkg::store_req_type req,
   output logic [7:0]            byte_rdata,
   output logic                  mark_rdata
);

   logic [7:0] byte_mem [sra_pkg::CAPACITY];
   logic       mark_mem [sra_pkg::CAPACITY];
   logic [7:0] byte_rdata_ff;
   logic       mark_rdata_ff;

   // Byte store: single port, registered read
   always_ff @(posedge clock) begin
      if (req.byte_we) begin
         byte_mem[req.byte_addr] <= req.byte_wdata;
      end
      if (req.byte_re) begin
         byte_rdata_ff <= byte_mem[req.byte_addr];
      end
   end

   // Pending marks: single port, registered read
   always_ff @(posedge clock) begin
      if (req.mark_we) begin
         mark_mem[req.mark_addr] <= req.mark_wdata;
      end
      if (req.mark_re) begin
         mark_rdata_ff <= mark_mem[req.mark_addr];
      end
   end

   assign byte_rdata = byte_rdata_ff;
   assign mark_rdata = mark_rdata_ff;

endmodule

// File: tb/sv/stream_byte_reassembler_checker.sv
`timescale 1ns / 1ps

module stream_byte_reassembler_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  sra_pkg::req_item_type req_item,
   input  logic                  rsp_strobe,
   input  sra_pkg::rsp_item_type rsp_item,
   output int unsigned           mismatch_count,
   output int unsigned           owed_results
);

   // Mirror of the stream state
   logic [7:0]   mirror_bytes [sra_pkg::CAPACITY];
   bit           mirror_marks [sra_pkg::CAPACITY];
   logic [63:0]  frontier;
   logic [63:0]  read_pos;
   logic [63:0]  end_pos;
   bit           end_seen;
   bit           closed;
   int unsigned  stored_ahead;
   int unsigned  results_checked;

   // Status predicted for each accepted item, oldest first
   sra_pkg::rsp_item_type owed_status [$];

   function automatic int slot_for(logic [63:0] pos);
      return int'(pos % 64'(sra_pkg::CAPACITY));
   endfunction

   function automatic void close_if_reached();
      if (end_seen && end_pos == frontier) closed = 1'b1;
   endfunction

   // Store one segment byte, then walk the frontier over contiguous bytes
   function automatic void store_segment(logic [63:0] pos, logic [7:0] value, logic last);
      logic [63:0] used;
      logic [63:0] room;
      int          s;
      used = frontier - read_pos;
      if (closed || used >= 64'(sra_pkg::CAPACITY)) return;
      room = 64'(sra_pkg::CAPACITY) - used;
      if (pos < frontier || pos - frontier >= room) return;
      if (last && !end_seen) begin
         end_seen = 1'b1;
         end_pos  = pos + 64'd1;
      end
      s = slot_for(pos);
      mirror_bytes[s] = value;
      if (!mirror_marks[s]) begin
         mirror_marks[s] = 1'b1;
         stored_ahead++;
      end
      while (mirror_marks[slot_for(frontier)] &&
             frontier - read_pos < 64'(sra_pkg::CAPACITY)) begin
         mirror_marks[slot_for(frontier)] = 1'b0;
         stored_ahead--;
         frontier++;
      end
      close_if_reached();
   endfunction

   // Apply one item to the mirror and return the status it should give
   function automatic sra_pkg::rsp_item_type next_status(sra_pkg::req_item_type it);
      sra_pkg::rsp_item_type res;
      res = '0;
      case (it.operation)
         sra_pkg::OP_SEGMENT: store_segment(it.stream_index, it.data_byte, it.is_last);
         sra_pkg::OP_MARKER: begin
            if (it.is_last && !end_seen) begin
               end_seen = 1'b1;
               end_pos  = it.stream_index;
            end
            close_if_reached();
         end
         sra_pkg::OP_READ: begin
            if (frontier != read_pos) begin
               res.read_byte  = mirror_bytes[slot_for(read_pos)];
               res.read_valid = 1'b1;
               read_pos++;
            end
         end
         default: ;
      endcase
      res.assembled_count = frontier;
      res.pending_count   = sra_pkg::PEND_W'(stored_ahead);
      res.stream_closed   = closed;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("result %0d %s: got %0h, want %0h", results_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      sra_pkg::rsp_item_type want;
      if (reset) begin
         // clear the mirror; the byte store keeps whatever it holds
         for (int i = 0; i < sra_pkg::CAPACITY; i++) mirror_marks[i] = 1'b0;
         frontier        = '0;
         read_pos        = '0;
         end_pos         = '0;
         end_seen        = 1'b0;
         closed          = 1'b0;
         stored_ahead    = 0;
         results_checked = 0;
         mismatch_count  = 0;
         owed_status.delete();
         owed_results <= 0;
      end else begin
         // score the result shown this cycle against the oldest prediction
         if (rsp_strobe) begin
            if (owed_status.size() == 0) begin
               report_mismatch("result with no item owed", rsp_item.assembled_count, '0);
            end else begin
               want = owed_status.pop_front();
               compare_field("read_byte", 64'(rsp_item.read_byte), 64'(want.read_byte));
               compare_field("read_valid", 64'(rsp_item.read_valid), 64'(want.read_valid));
               compare_field("assembled_count", rsp_item.assembled_count,
                             want.assembled_count);
               compare_field("pending_count", 64'(rsp_item.pending_count),
                             64'(want.pending_count));
               compare_field("stream_closed", 64'(rsp_item.stream_closed),
                             64'(want.stream_closed));
            end
            results_checked++;
         end
         // predict the item taken at this edge
         if (start && !busy) owed_status.push_back(next_status(req_item));
         owed_results <= unsigned'(owed_status.size());
      end
   end

endmodule

// File: tb/sv/stream_byte_reassembler_test.sv
`timescale 1ns / 1ps

module stream_byte_reassembler_test;

   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam int unsigned STALL_LIMIT = 10000;
   localparam int unsigned MIX_ITEMS   = 170;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   sra_pkg::req_item_type req_item = '0;
   logic                  busy;
   logic                  rsp_strobe;
   sra_pkg::rsp_item_type rsp_item;
   int unsigned           mismatch_count;
   int unsigned           owed_results;
   int unsigned           sender_idle  = 11;
   int unsigned           work_items   = 0;
   int unsigned           quiet_cycles = 0;
   logic [63:0]           seen_assembled;
   logic [63:0]           seen_read;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   stream_byte_reassembler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   stream_byte_reassembler_checker monitor (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .owed_results   (owed_results)
   );

   // Track the frontier and the read position from the results, to aim the stimulus
   always @(posedge clock) begin
      if (reset) begin
         seen_assembled <= '0;
         seen_read      <= '0;
      end else if (rsp_strobe) begin
         seen_assembled <= rsp_item.assembled_count;
         if (rsp_item.read_valid) seen_read <= seen_read + 64'd1;
      end
   end

   // End the run when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("stream_byte_reassembler_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, idling first at random, and hold it until it is taken
   task automatic send_item(input logic [1:0] op, input logic [63:0] pos,
                            input logic [7:0] value, input logic last);
      if (sender_idle != 0 && $urandom_range(0, 99) < sender_idle) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle);
      end
      start    <= 1'b1;
      req_item <= '{operation: op, stream_index: pos, data_byte: value, is_last: last};
      if (op != OP_UNUSED) work_items++;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_read();
      send_item(sra_pkg::OP_READ, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
   endtask

   // Send a run of consecutive bytes in shuffled order, some of them twice;
   // optionally flag the highest position as the stream end
   task automatic send_run(input logic [63:0] first, input int count, input bit tail_last);
      int          order [32];
      int          pick;
      int          hold;
      logic [63:0] pos;
      logic        tag;
      for (int i = 0; i < count; i++) order[i] = i;
      for (int i = count - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         hold        = order[i];
         order[i]    = order[pick];
         order[pick] = hold;
      end
      for (int i = 0; i < count; i++) begin
         pos = first + 64'(order[i]);
         tag = tail_last && (order[i] == count - 1);
         send_item(sra_pkg::OP_SEGMENT, pos, 8'($urandom), tag);
         if ($urandom_range(0, 9) == 0) send_item(sra_pkg::OP_SEGMENT, pos, 8'($urandom), tag);
      end
   endtask

   // Drop start and wait until every result has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (owed_results != 0);
   endtask

   // Mostly runs near the frontier and reads, with some noise
   task automatic run_mix(input int unsigned target);
      int unsigned goal;
      int unsigned pick;
      logic [63:0] ahead;
      goal = work_items + target;
      while (work_items < goal) begin
         pick = $urandom_range(0, 99);
         if (seen_assembled - seen_read > 64'd600) pick = 60;
         if (pick < 45) begin
            ahead = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 3));
            send_run(seen_assembled + ahead, $urandom_range(1, 12), 1'b0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 16)) send_read();
         end else begin
            case ($urandom_range(0, 4))
               0: send_item(sra_pkg::OP_SEGMENT, {$urandom, $urandom}, 8'($urandom),
                            1'($urandom));
               1: send_item(sra_pkg::OP_SEGMENT,
                            seen_assembled - 64'($urandom_range(1, 64)),
                            8'($urandom), 1'($urandom));
               2: send_item(sra_pkg::OP_SEGMENT,
                            seen_read + 64'(sra_pkg::CAPACITY) + 64'($urandom_range(1, 200)),
                            8'($urandom), 1'($urandom));
               3: send_item(sra_pkg::OP_MARKER, {$urandom, $urandom}, 8'($urandom), 1'b0);
               default: send_item(OP_UNUSED, {$urandom, $urandom}, 8'($urandom),
                                  1'($urandom));
            endcase
         end
      end
   endtask

   // Fix the stream end one of several ways, then poke the stream, closed unless the end fell behind the frontier
   task automatic close_stream();
      int          span;
      logic [63:0] stop_pos;
      repeat (int'(seen_assembled - seen_read)) send_read();
      settle();
      span     = $urandom_range(20, 28);
      stop_pos = seen_assembled + 64'(span);
      case ($urandom_range(0, 5))
         0: begin
            // end behind the frontier: the stream stays open
            send_item(sra_pkg::OP_MARKER, seen_assembled - 64'($urandom_range(1, 32)),
                      8'($urandom), 1'b1);
            send_run(seen_assembled, 12, 1'b0);
         end
         1: begin
            send_item(sra_pkg::OP_MARKER, stop_pos, 8'($urandom), 1'b1);
            send_item(sra_pkg::OP_MARKER, stop_pos + 64'd5, 8'($urandom), 1'b1);
            send_run(seen_assembled, span, 1'b0);
         end
         2: send_item(sra_pkg::OP_MARKER, seen_assembled, 8'($urandom), 1'b1);
         default: send_run(seen_assembled, span, 1'b1);
      endcase
      settle();
      repeat (40) begin
         case ($urandom_range(0, 3))
            0: send_item(sra_pkg::OP_SEGMENT, seen_assembled + 64'($urandom_range(0, 4)),
                         8'($urandom), 1'($urandom));
            1: send_item(sra_pkg::OP_MARKER, {$urandom, $urandom}, 8'($urandom),
                         1'($urandom));
            2: send_read();
            default: send_item(OP_UNUSED, {$urandom, $urandom}, 8'($urandom),
                               1'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, unused code, markers, window edges, overwrite, walk
      send_read();
      send_item(OP_UNUSED, '1, 8'hFF, 1'b1);
      send_item(sra_pkg::OP_MARKER, '1, 8'h00, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, 64'd1, 8'h00, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, 64'd1, 8'hFF, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, '1, 8'hA5, 1'b1);
      send_item(sra_pkg::OP_SEGMENT, 64'(sra_pkg::CAPACITY), 8'h5A, 1'b1);
      send_item(sra_pkg::OP_SEGMENT, 64'(sra_pkg::CAPACITY - 1), 8'hC3, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, 64'd0, 8'h3C, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, 64'd0, 8'h77, 1'b1);
      send_read();
      send_read();
      send_read();
      send_item(sra_pkg::OP_MARKER, 64'd0, 8'h00, 1'b0);
      send_item(OP_UNUSED, 64'd0, 8'h00, 1'b0);
      send_item(sra_pkg::OP_SEGMENT, 64'd2, 8'h01, 1'b0);
      send_read();

      run_mix(MIX_ITEMS);
      settle();
      sender_idle = 58;
      run_mix(MIX_ITEMS);
      settle();
      sender_idle = 0;
      run_mix(MIX_ITEMS);
      settle();
      close_stream();
      settle();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("stream_byte_reassembler_test: clean");
      end else begin
         $display("stream_byte_reassembler_test: errors");
      end
      $finish;
   end

endmodule
